// ----- src/dsfp_pkg.sv -----
// Package for the display serial frame parser.
// Holds frame constants, state encoding, config register codes and shared structs.
// No dependencies.
package dsfp_pkg;

    localparam int MaxPayload = 64;
    localparam int CountW     = $clog2(MaxPayload + 1);
    localparam int CmpW       = (CountW > 8) ? CountW : 8;
    localparam int IndexW     = 6;
    localparam int CfgIdxW    = 1;

    localparam logic [7:0] HeaderFirstRst  = 8'h5A;
    localparam logic [7:0] HeaderSecondRst = 8'hA5;
    localparam logic [7:0] CmdWriteAck     = 8'h82;
    localparam logic [7:0] CmdRead         = 8'h83;
    localparam logic [7:0] LenOverhead     = 8'd4;

    typedef enum logic [CfgIdxW-1:0] {
        REG_HEADER_FIRST  = 1'b0,
        REG_HEADER_SECOND = 1'b1
    } cfg_reg_t;

    typedef enum logic [7:0] {
        ST_HEAD1   = 8'b0000_0001,
        ST_HEAD2   = 8'b0000_0010,
        ST_LENGTH  = 8'b0000_0100,
        ST_COMMAND = 8'b0000_1000,
        ST_ADDR_HI = 8'b0001_0000,
        ST_ADDR_LO = 8'b0010_0000,
        ST_COUNT   = 8'b0100_0000,
        ST_PAYLOAD = 8'b1000_0000
    } parse_state_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
    } hdr_cfg_t;

    typedef struct packed {
        logic [15:0]       var_address;
        logic [7:0]        word_count;
        logic [IndexW-1:0] byte_index;
        logic [7:0]        payload_byte;
        logic              frame_end;
    } result_t;

endpackage

// ----- src/dsfp_if.sv -----
// Channel interfaces for the display serial frame parser.
// Depends on dsfp_pkg for field widths.
interface dsfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfp_result_if;
    logic                          valid;
    logic                          ready;
    logic [15:0]                   var_address;
    logic [7:0]                    word_count;
    logic [dsfp_pkg::IndexW-1:0]   byte_index;
    logic [7:0]                    payload_byte;
    logic                          frame_end;

    modport source (output valid, output var_address, output word_count,
                    output byte_index, output payload_byte, output frame_end,
                    input ready);
    modport sink (input valid, input var_address, input word_count,
                  input byte_index, input payload_byte, input frame_end,
                  output ready);
endinterface

interface dsfp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dsfp_pkg::CfgIdxW-1:0] index;
    logic [7:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/dsfp_cfg_regs.sv -----
// Configuration registers: header match bytes.
// Depends on dsfp_pkg and dsfp_cfg_if.
module dsfp_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    dsfp_cfg_if.sink          cfg,
    output dsfp_pkg::hdr_cfg_t hdr_cfg
);

    dsfp_pkg::hdr_cfg_t hdr_reg;

    assign cfg.ready = 1'b1;
    assign hdr_cfg   = hdr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg.header_first  <= dsfp_pkg::HeaderFirstRst;
            hdr_reg.header_second <= dsfp_pkg::HeaderSecondRst;
        end
        else if (cfg.valid)
        begin
            unique case (dsfp_pkg::cfg_reg_t'(cfg.index))
                dsfp_pkg::REG_HEADER_FIRST:  hdr_reg.header_first  <= cfg.data;
                dsfp_pkg::REG_HEADER_SECOND: hdr_reg.header_second <= cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/dsfp_parser.sv -----
// Frame parser state machine: header match, length, command, address, then count and payload for reads.
// Produces at most one result per byte. Depends on dsfp_pkg.
module dsfp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  dsfp_pkg::hdr_cfg_t hdr_cfg,
    output logic               res_valid,
    output dsfp_pkg::result_t  res
);

    dsfp_pkg::parse_state_t state_reg, state_next;
    logic                          is_read_reg, is_read_next;
    logic [dsfp_pkg::CountW-1:0]   count_reg, count_next;
    logic [7:0]                    remain_reg, remain_next;
    logic [15:0]                   addr_reg, addr_next;
    logic [7:0]                    wcount_reg, wcount_next;

    logic [dsfp_pkg::CountW-1:0]   count_inc;
    logic [dsfp_pkg::CmpW-1:0]     count_inc_ext;
    logic [dsfp_pkg::CmpW-1:0]     count_ext;
    logic                          last;

    assign count_inc     = count_reg + 1'b1;
    assign count_inc_ext = dsfp_pkg::CmpW'(count_inc);
    assign count_ext     = dsfp_pkg::CmpW'(count_reg);
    assign last = (count_inc_ext >= dsfp_pkg::CmpW'(remain_reg)) ||
                  (count_inc_ext >= dsfp_pkg::CmpW'(dsfp_pkg::MaxPayload));

    always_comb
    begin
        state_next  = state_reg;
        is_read_next = is_read_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        addr_next   = addr_reg;
        wcount_next = wcount_reg;
        res_valid   = 1'b0;

        res.var_address  = addr_reg;
        res.word_count   = wcount_reg;
        res.byte_index   = count_ext[dsfp_pkg::IndexW-1:0];
        res.payload_byte = rx_byte;
        res.frame_end    = last;

        unique case (state_reg)
            dsfp_pkg::ST_HEAD2:
                state_next = (rx_byte == hdr_cfg.header_second) ?
                             dsfp_pkg::ST_LENGTH : dsfp_pkg::ST_HEAD1;
            dsfp_pkg::ST_LENGTH:
            begin
                remain_next = rx_byte;
                state_next  = dsfp_pkg::ST_COMMAND;
            end
            dsfp_pkg::ST_COMMAND:
            begin
                if (rx_byte == dsfp_pkg::CmdWriteAck || rx_byte == dsfp_pkg::CmdRead)
                begin
                    is_read_next = (rx_byte == dsfp_pkg::CmdRead);
                    state_next   = dsfp_pkg::ST_ADDR_HI;
                end
                else
                begin
                    state_next = dsfp_pkg::ST_HEAD1;
                end
            end
            dsfp_pkg::ST_ADDR_HI:
            begin
                addr_next  = {8'h00, rx_byte};
                state_next = dsfp_pkg::ST_ADDR_LO;
            end
            dsfp_pkg::ST_ADDR_LO:
            begin
                addr_next  = {addr_reg[7:0], rx_byte};
                state_next = is_read_reg ? dsfp_pkg::ST_COUNT : dsfp_pkg::ST_HEAD1;
            end
            dsfp_pkg::ST_COUNT:
            begin
                wcount_next = rx_byte;
                remain_next = remain_reg - dsfp_pkg::LenOverhead;
                count_next  = '0;
                state_next  = dsfp_pkg::ST_PAYLOAD;
            end
            dsfp_pkg::ST_PAYLOAD:
            begin
                res_valid  = 1'b1;
                count_next = count_inc;
                if (last)
                    state_next = dsfp_pkg::ST_HEAD1;
            end
            default:
                state_next = (rx_byte == hdr_cfg.header_first) ?
                             dsfp_pkg::ST_HEAD2 : dsfp_pkg::ST_HEAD1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dsfp_pkg::ST_HEAD1;
            is_read_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            is_read_reg <= is_read_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            remain_reg <= remain_next;
            addr_reg   <= addr_next;
            wcount_reg <= wcount_next;
        end
    end

    // payload index never reaches the frame limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsfp_pkg::ST_PAYLOAD |->
            count_ext < dsfp_pkg::CmpW'(dsfp_pkg::MaxPayload))
        else $error("payload index past limit");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && res.frame_end |=> state_reg == dsfp_pkg::ST_HEAD1)
        else $error("parser did not return to idle after last byte");

    a_count_start: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_reg == dsfp_pkg::ST_COUNT |=>
            state_reg == dsfp_pkg::ST_PAYLOAD && count_reg == '0)
        else $error("payload did not start at index zero");

endmodule

// ----- src/display_serial_frame_parser_top.sv -----
// Display serial frame parser, top level.
// Throughput 1 byte per cycle while the output register is empty or being drained.
// Input register feeds the parser state machine, whose result lands in an output register.
// The parser and output register advance when the output register is empty or being drained;
// the input register also takes a new byte whenever it is empty.
// Reset (rst_n, async low): idle, headers 0x5A/0xA5, both stages empty.
module display_serial_frame_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    dsfp_rx_if.sink     rx,
    dsfp_result_if.source result,
    dsfp_cfg_if.sink    cfg
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    dsfp_pkg::result_t  out_data_reg;

    dsfp_pkg::hdr_cfg_t hdr_cfg;
    logic               res_valid;
    dsfp_pkg::result_t  res;
    logic               out_free;
    logic               advance;
    logic               rx_take;

    assign out_free = !out_valid_reg || result.ready;
    assign advance  = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    dsfp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .hdr_cfg (hdr_cfg)
    );

    dsfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .hdr_cfg   (hdr_cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (out_free)
                out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            in_byte_reg <= rx.rx_byte;
        if (out_free && advance && res_valid)
            out_data_reg <= res;
    end

    assign result.valid        = out_valid_reg;
    assign result.var_address  = out_data_reg.var_address;
    assign result.word_count   = out_data_reg.word_count;
    assign result.byte_index   = out_data_reg.byte_index;
    assign result.payload_byte = out_data_reg.payload_byte;
    assign result.frame_end    = out_data_reg.frame_end;

    a_rx_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rx_take |=> in_valid_reg)
        else $error("rx transaction lost at input register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg)
        else $error("pending result dropped");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register changed while stalled");

endmodule
